FILE: design/palm_pkg.sv
`timescale 1ns / 1ps

package palm_pkg;

    // history size default
    localparam int HIST_DEPTH_DEF = 2048;

    // pair field layout
    localparam int DIST_W   = 11;
    localparam int LEN_W    = 4;
    localparam logic [LEN_W-1:0] LEN_BASE = 4'd3;

    // token class bounds
    localparam logic [7:0] TOK_ZERO     = 8'h00;
    localparam logic [7:0] TOK_RUN_MAX  = 8'h08;
    localparam logic [7:0] TOK_LIT_MAX  = 8'h7F;
    localparam logic [7:0] TOK_PAIR_MAX = 8'hBF;
    localparam logic [7:0] TOK_XOR      = 8'h80;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_TRUNC = 2'd1,
        STAT_ZERO  = 2'd2,
        STAT_FAR   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SPACE,
        ENG_PAIR_RD,
        ENG_COPY
    } eng_state_t;

    // one result item from the engine
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last_of_run;
        logic       record_end;
        status_t    status;
    } res_t;

endpackage

FILE: design/palm_hist_mem.sv
`timescale 1ns / 1ps

module palm_hist_mem #(
    parameter int DEPTH = palm_pkg::HIST_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, new data wins on a same-address write
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/palm_engine.sv
`timescale 1ns / 1ps

module palm_engine #(
    parameter int HIST_DEPTH = palm_pkg::HIST_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    in_byte,
    input  logic                          last_in_record,
    input  logic                          emit_ok,
    output logic                          res_valid,
    output palm_pkg::res_t                res,
    output logic                          mem_we,
    output logic [$clog2(HIST_DEPTH)-1:0] mem_waddr,
    output logic [7:0]                    mem_wdata,
    output logic [$clog2(HIST_DEPTH)-1:0] mem_raddr,
    input  logic [7:0]                    mem_rdata
);

    localparam int AW    = $clog2(HIST_DEPTH);
    localparam int CNT_W = AW + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HIST_DEPTH);

    palm_pkg::eng_state_t state_reg, state_next;

    logic [AW-1:0]              wp_reg, wp_next;
    logic [CNT_W-1:0]           bw_reg, bw_next;
    logic [3:0]                 lit_reg, lit_next;
    logic                       pend_reg, pend_next;
    logic [7:0]                 high_reg, high_next;
    logic                       stop_reg, stop_next;
    logic                       last_reg, last_next;
    logic [AW-1:0]              src_reg, src_next;
    logic [palm_pkg::LEN_W-1:0] len_reg, len_next;
    logic [7:0]                 sec_reg, sec_next;

    logic [15:0]                   pair;
    logic [palm_pkg::DIST_W-1:0]   pair_dist;
    logic [palm_pkg::LEN_W-1:0]    pair_len;
    logic                          do_emit;
    logic [7:0]                    emit_data;
    logic                          restart;

    // pair decode
    assign pair      = {high_reg, in_byte};
    assign pair_dist = pair[13:3];
    assign pair_len  = {1'b0, pair[2:0]} + palm_pkg::LEN_BASE;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= palm_pkg::ENG_IDLE;
            wp_reg    <= '0;
            bw_reg    <= '0;
            lit_reg   <= '0;
            pend_reg  <= 1'b0;
            high_reg  <= '0;
            stop_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            bw_reg    <= bw_next;
            lit_reg   <= lit_next;
            pend_reg  <= pend_next;
            high_reg  <= high_next;
            stop_reg  <= stop_next;
            last_reg  <= last_next;
        end
    end

    // copy and space payload
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        len_reg <= len_next;
        sec_reg <= sec_next;
    end

    // token decode and copy sequencing
    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        bw_next    = bw_reg;
        lit_next   = lit_reg;
        pend_next  = pend_reg;
        high_next  = high_reg;
        stop_next  = stop_reg;
        last_next  = last_reg;
        src_next   = src_reg;
        len_next   = len_reg;
        sec_next   = sec_reg;
        in_stall   = 1'b1;
        res_valid  = 1'b0;
        res        = '0;
        do_emit    = 1'b0;
        emit_data  = '0;
        restart    = 1'b0;
        mem_raddr  = src_reg;

        unique case (state_reg)
            palm_pkg::ENG_IDLE:
            begin
                in_stall = !emit_ok;
                if (in_valid && emit_ok)
                begin
                    res.last_of_run = 1'b1;
                    res.record_end  = last_in_record;
                    restart         = last_in_record;
                    priority if (stop_reg)
                    begin
                        res_valid  = last_in_record;
                        res.status = palm_pkg::STAT_ZERO;
                    end
                    else if (lit_reg != '0)
                    begin
                        lit_next  = lit_reg - 4'd1;
                        do_emit   = 1'b1;
                        emit_data = in_byte;
                    end
                    else if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        priority if (pair_dist == '0)
                        begin
                            stop_next  = 1'b1;
                            res_valid  = 1'b1;
                            res.status = palm_pkg::STAT_ZERO;
                        end
                        else if (CNT_W'(pair_dist) > bw_reg)
                        begin
                            res_valid  = 1'b1;
                            res.status = palm_pkg::STAT_FAR;
                        end
                        else
                        begin
                            // launch the copy, record end waits for its last byte
                            restart    = 1'b0;
                            src_next   = wp_reg - AW'(pair_dist);
                            len_next   = pair_len;
                            last_next  = last_in_record;
                            state_next = palm_pkg::ENG_PAIR_RD;
                        end
                    end
                    else if (in_byte == palm_pkg::TOK_ZERO)
                    begin
                        do_emit   = 1'b1;
                        emit_data = '0;
                    end
                    else if (in_byte <= palm_pkg::TOK_RUN_MAX)
                    begin
                        lit_next   = in_byte[3:0];
                        res_valid  = last_in_record;
                        res.status = palm_pkg::STAT_OK;
                    end
                    else if (in_byte <= palm_pkg::TOK_LIT_MAX)
                    begin
                        do_emit   = 1'b1;
                        emit_data = in_byte;
                    end
                    else if (in_byte <= palm_pkg::TOK_PAIR_MAX)
                    begin
                        pend_next  = 1'b1;
                        high_next  = in_byte;
                        res_valid  = last_in_record;
                        res.status = palm_pkg::STAT_TRUNC;
                    end
                    else
                    begin
                        // space first, then the byte with its top bit flipped
                        do_emit         = 1'b1;
                        emit_data       = palm_pkg::CHAR_SPACE;
                        res.last_of_run = 1'b0;
                        res.record_end  = 1'b0;
                        restart         = 1'b0;
                        sec_next        = in_byte ^ palm_pkg::TOK_XOR;
                        last_next       = last_in_record;
                        state_next      = palm_pkg::ENG_SPACE;
                    end
                end
            end

            palm_pkg::ENG_SPACE:
            begin
                if (emit_ok)
                begin
                    do_emit         = 1'b1;
                    emit_data       = sec_reg;
                    res.last_of_run = 1'b1;
                    res.record_end  = last_reg;
                    restart         = last_reg;
                    state_next      = palm_pkg::ENG_IDLE;
                end
            end

            palm_pkg::ENG_PAIR_RD:
            begin
                // first history read in flight
                state_next = palm_pkg::ENG_COPY;
            end

            palm_pkg::ENG_COPY:
            begin
                if (emit_ok)
                begin
                    do_emit         = 1'b1;
                    emit_data       = mem_rdata;
                    res.last_of_run = (len_reg == 4'd1);
                    res.record_end  = last_reg && (len_reg == 4'd1);
                    src_next        = src_reg + 1'b1;
                    mem_raddr       = src_reg + 1'b1;
                    len_next        = len_reg - 4'd1;
                    if (len_reg == 4'd1)
                    begin
                        restart    = last_reg;
                        state_next = palm_pkg::ENG_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = palm_pkg::ENG_IDLE;
            end
        endcase

        // data byte goes out and into the history
        if (do_emit)
        begin
            res_valid      = 1'b1;
            res.data       = emit_data;
            res.byte_valid = 1'b1;
            res.status     = palm_pkg::STAT_OK;
            wp_next        = wp_reg + 1'b1;
            if (bw_reg != CNT_MAX)
            begin
                bw_next = bw_reg + 1'b1;
            end
        end

        // record boundary clears all record state
        if (restart)
        begin
            wp_next   = '0;
            bw_next   = '0;
            lit_next  = '0;
            pend_next = 1'b0;
            high_next = '0;
            stop_next = 1'b0;
            last_next = 1'b0;
        end
    end

    assign mem_we    = do_emit;
    assign mem_waddr = wp_reg;
    assign mem_wdata = emit_data;

endmodule

FILE: design/palmdoc_lz77_decompressor_top.sv
`timescale 1ns / 1ps

// PalmDOC LZ77 decompressor: takes one compressed byte of a record per input
// item and gives one output item per decompressed byte, plus status-only items
// for stops, truncated pairs, out-of-range distances and records that end on
// a silent token. A space-plus-byte token gives a space, then its byte with the
// top bit flipped. The second byte of a back-reference pair starts a copy of
// its length (3 to 10), one byte per cycle while the output can drain, from
// the single-port-read 2048-byte history by a registered read and same-address
// write forwarding for overlapping copies. No new input is taken while an item
// is still being worked on or a result waits in the output register and
// out_stall is high. History and counters restart after each last_in_record.
module palmdoc_lz77_decompressor_top #(
    parameter int HIST_DEPTH = palm_pkg::HIST_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_in_record,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_run,
    output logic       record_end,
    output logic [1:0] status
);

    localparam int AW = $clog2(HIST_DEPTH);

    logic           emit_ok;
    logic           res_valid;
    palm_pkg::res_t res;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     mem_rdata;

    logic           out_valid_reg;
    palm_pkg::res_t out_res_reg;

    palm_engine #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .last_in_record (last_in_record),
        .emit_ok        (emit_ok),
        .res_valid      (res_valid),
        .res            (res),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    palm_hist_mem #(
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register is free or drains this cycle
    assign emit_ok = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_res_reg.data;
    assign byte_valid  = out_res_reg.byte_valid;
    assign last_of_run = out_res_reg.last_of_run;
    assign record_end  = out_res_reg.record_end;
    assign status      = out_res_reg.status;

    // engine never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten in output register");

    // status-only items always close their input
    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> last_of_run)
        else $error("status-only item without last_of_run");

    // data items carry ok status
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (status == palm_pkg::STAT_OK))
        else $error("data item with error status");

    // a record ends only on the last item of an input
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_end) |-> last_of_run)
        else $error("record_end without last_of_run");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HIST_SIZE = 2048;
    localparam int LONG_HOLD = 250;

    typedef struct {
        logic [7:0]     b;
        logic           l;
        int             n;
        palm_pkg::res_t r;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       last_in_record;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       record_end;
    logic [1:0] status;

    // decoder shadow state
    logic [7:0]  hist [0:HIST_SIZE-1];
    logic [10:0] wpos;
    logic [11:0] nbytes;
    logic [3:0]  raw_left;
    logic        pend;
    logic [7:0]  pend_hi;
    logic        halted;

    palm_pkg::res_t out_due[$];
    palm_pkg::res_t last_run[$];
    logic [7:0]     seq_q[$];
    dir_row_t       rows[$];

    int fails;
    int fed;
    bit idle_on;
    bit hold_req;

    palmdoc_lz77_decompressor_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .last_in_record (last_in_record),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last_of_run    (last_of_run),
        .record_end     (record_end),
        .status         (status)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic palm_pkg::res_t mk(input logic [7:0] b, input logic v,
                                          input logic lr, input logic re,
                                          input palm_pkg::status_t st);
        palm_pkg::res_t r;
        r = '0;
        r.data        = b;
        r.byte_valid  = v;
        r.last_of_run = lr;
        r.record_end  = re;
        r.status      = st;
        return r;
    endfunction

    // back-reference pair: 2'b10, 11-bit distance, length minus three
    function automatic logic [15:0] pair_code(input int back_dist, input int len);
        logic [10:0] d;
        logic [2:0]  n;
        d = 11'(back_dist);
        n = 3'(len - 3);
        return {2'b10, d, n};
    endfunction

    task automatic lz_restart();
        wpos     = '0;
        nbytes   = '0;
        raw_left = '0;
        pend     = 1'b0;
        pend_hi  = '0;
        halted   = 1'b0;
    endtask

    task automatic emit(input logic [7:0] v);
        hist[wpos] = v;
        wpos = wpos + 11'd1;
        if (nbytes < HIST_SIZE)
            nbytes = nbytes + 12'd1;
        last_run.insert(last_run.size(), mk(v, 1'b1, 1'b0, 1'b0, palm_pkg::STAT_OK));
    endtask

    task automatic mark(input palm_pkg::status_t st);
        last_run.insert(last_run.size(), mk(8'h00, 1'b0, 1'b0, 1'b0, st));
    endtask

    // decode one compressed byte, leave its output items in last_run and queue them
    task automatic lz_decode(input logic [7:0] c, input logic l);
        palm_pkg::status_t tail;
        logic [15:0]       pr;
        logic [10:0]       back_dist;
        logic [3:0]        len;
        palm_pkg::res_t    r;
        int                k;
        last_run.delete();
        tail = palm_pkg::STAT_OK;
        if (halted)
            tail = palm_pkg::STAT_ZERO;
        else if (raw_left != 0)
        begin
            raw_left = raw_left - 4'd1;
            emit(c);
        end
        else if (pend)
        begin
            pr        = {pend_hi, c};
            back_dist = pr[13:3];
            len       = {1'b0, pr[2:0]} + palm_pkg::LEN_BASE;
            pend      = 1'b0;
            if (back_dist == 0)
            begin
                halted = 1'b1;
                mark(palm_pkg::STAT_ZERO);
            end
            else if (back_dist > nbytes)
                mark(palm_pkg::STAT_FAR);
            else
                for (int j = 0; j < len; j++)
                    emit(hist[wpos - back_dist]);
        end
        else if (c == palm_pkg::TOK_ZERO)
            emit(8'h00);
        else if (c <= palm_pkg::TOK_RUN_MAX)
            raw_left = c[3:0];
        else if (c <= palm_pkg::TOK_LIT_MAX)
            emit(c);
        else if (c <= palm_pkg::TOK_PAIR_MAX)
        begin
            pend    = 1'b1;
            pend_hi = c;
            tail    = palm_pkg::STAT_TRUNC;
        end
        else
        begin
            emit(palm_pkg::CHAR_SPACE);
            emit(c ^ palm_pkg::TOK_XOR);
        end

        if (l && last_run.size() == 0)
            mark(tail);
        k = last_run.size();
        if (k > 0)
        begin
            r = last_run[k-1];
            r.last_of_run = 1'b1;
            r.record_end  = l;
            last_run[k-1] = r;
        end
        for (int j = 0; j < k; j++)
            out_due.insert(out_due.size(), last_run[j]);
        if (l)
            lz_restart();
    endtask

    // offer one item and hold it until taken
    task automatic send_item(input logic [7:0] b, input logic l);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_byte        <= b;
        last_in_record <= l;
        do
            @(posedge clk);
        while (in_stall);
        if (!halted)
            fed++;
        lz_decode(b, l);
    endtask

    task automatic flush_seq();
        for (int i = 0; i < seq_q.size(); i++)
            send_item(seq_q[i], i == seq_q.size() - 1);
    endtask

    // one record of random tokens; wild records also get far and zero
    // distances, corrupted bytes and early cuts
    task automatic send_record(input int n_tok, input bit wild);
        int          made;
        int          kind;
        int          k;
        int          back_dist;
        int          len;
        int          pick;
        logic [15:0] code;
        seq_q.delete();
        made = 0;
        for (int t = 0; t < n_tok; t++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    seq_q.insert(seq_q.size(), 8'h00);
                    made++;
                end
                1, 2:
                begin
                    seq_q.insert(seq_q.size(), 8'($urandom_range(9, 127)));
                    made++;
                end
                3:
                begin
                    seq_q.insert(seq_q.size(), 8'($urandom_range(192, 255)));
                    made += 2;
                end
                4, 5:
                begin
                    k = $urandom_range(1, 8);
                    seq_q.insert(seq_q.size(), 8'(k));
                    repeat (k) seq_q.insert(seq_q.size(), 8'($urandom_range(0, 255)));
                    made += k;
                end
                default:
                begin
                    pick = wild ? $urandom_range(0, 9) : 9;
                    len  = $urandom_range(3, 10);
                    if (pick == 0 && made < HIST_SIZE - 1)
                        back_dist = $urandom_range(made + 1, HIST_SIZE - 1);
                    else if (pick == 1)
                        back_dist = 0;
                    else if (made == 0)
                    begin
                        // nothing to copy yet, give a literal instead
                        seq_q.insert(seq_q.size(), 8'($urandom_range(9, 127)));
                        made++;
                        continue;
                    end
                    else
                    begin
                        back_dist = $urandom_range(1,
                                                   made < HIST_SIZE - 1 ? made : HIST_SIZE - 1);
                        made += len;
                    end
                    code = pair_code(back_dist, len);
                    seq_q.insert(seq_q.size(), code[15:8]);
                    seq_q.insert(seq_q.size(), code[7:0]);
                end
            endcase
        end
        if (wild && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                seq_q[$urandom_range(0, seq_q.size() - 1)] = 8'($urandom_range(0, 255));
        if (wild && $urandom_range(0, 2) == 0)
        begin
            k = $urandom_range(1, seq_q.size());
            while (seq_q.size() > k)
                void'(seq_q.pop_back());
        end
        flush_seq();
    endtask

    // receiver stall: short random bursts, or a long hold when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // output item checker
    always @(posedge clk)
    begin : watch_out
        palm_pkg::res_t want;
        palm_pkg::res_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = mk(out_byte, byte_valid, last_of_run, record_end,
                     palm_pkg::status_t'(status));
            if (out_due.size() == 0)
            begin
                $display("%0t: unexpected item byte=%h v=%b lr=%b re=%b st=%0d",
                         $time, got.data, got.byte_valid, got.last_of_run,
                         got.record_end, got.status);
                fails++;
            end
            else
            begin
                want = out_due.pop_front();
                if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
                    got.last_of_run !== want.last_of_run ||
                    got.record_end !== want.record_end || got.status !== want.status)
                begin
                    $display("%0t: mismatch exp byte=%h v=%b lr=%b re=%b st=%0d", $time,
                             want.data, want.byte_valid, want.last_of_run,
                             want.record_end, want.status);
                    $display("%0t:          got byte=%h v=%b lr=%b re=%b st=%0d", $time,
                             got.data, got.byte_valid, got.last_of_run,
                             got.record_end, got.status);
                    fails++;
                end
            end
        end
    end

    task automatic add_row(input logic [7:0] b, input logic l, input int n,
                           input palm_pkg::res_t r);
        dir_row_t row;
        row.b = b;
        row.l = l;
        row.n = n;
        row.r = r;
        rows.insert(rows.size(), row);
    endtask

    // stimulus
    initial
    begin
        int             made;
        int             back_dist;
        int             len;
        logic [15:0]    code;
        palm_pkg::res_t nil;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        last_in_record = 1'b0;
        idle_on        = 1'b0;
        hold_req       = 1'b0;
        fails          = 0;
        fed            = 0;
        lz_restart();
        nil = mk(8'h00, 1'b0, 1'b0, 1'b0, palm_pkg::STAT_OK);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // literals, space tokens, a full raw run of extreme bytes, a long copy
        add_row(8'h00, 1'b0, 1, mk(8'h00, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'h09, 1'b0, 1, mk(8'h09, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'h7F, 1'b0, 1, mk(8'h7F, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'hC0, 1'b0, -1, nil);
        add_row(8'hFF, 1'b0, -1, nil);
        add_row(8'h08, 1'b0, 0, nil);
        add_row(8'h00, 1'b0, 1, mk(8'h00, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'h80, 1'b0, 1, mk(8'h80, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'hFF, 1'b0, 1, mk(8'hFF, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'hC0, 1'b0, 1, mk(8'hC0, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'h01, 1'b0, 1, mk(8'h01, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'h55, 1'b0, 1, mk(8'h55, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'hAA, 1'b0, 1, mk(8'hAA, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'hBF, 1'b0, 1, mk(8'hBF, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'h80, 1'b0, 0, nil);
        add_row(8'h0F, 1'b0, -1, nil);
        // record ends on a raw count
        add_row(8'h01, 1'b1, 1, mk(8'h00, 1'b0, 1'b1, 1'b1, palm_pkg::STAT_OK));
        // distances beyond the output so far, then a cut pair
        add_row(8'h41, 1'b0, 1, mk(8'h41, 1'b1, 1'b1, 1'b0, palm_pkg::STAT_OK));
        add_row(8'h80, 1'b0, 0, nil);
        add_row(8'h10, 1'b0, 1, mk(8'h00, 1'b0, 1'b1, 1'b0, palm_pkg::STAT_FAR));
        add_row(8'hBF, 1'b0, 0, nil);
        add_row(8'hFF, 1'b0, 1, mk(8'h00, 1'b0, 1'b1, 1'b0, palm_pkg::STAT_FAR));
        add_row(8'h80, 1'b1, 1, mk(8'h00, 1'b0, 1'b1, 1'b1, palm_pkg::STAT_TRUNC));
        // zero distance stops the record
        add_row(8'h80, 1'b0, 0, nil);
        add_row(8'h07, 1'b0, 1, mk(8'h00, 1'b0, 1'b1, 1'b0, palm_pkg::STAT_ZERO));
        add_row(8'h41, 1'b0, 0, nil);
        add_row(8'h42, 1'b1, 1, mk(8'h00, 1'b0, 1'b1, 1'b1, palm_pkg::STAT_ZERO));

        idle_on = 1'b1;
        foreach (rows[i])
        begin
            send_item(rows[i].b, rows[i].l);
            if (rows[i].n >= 0 && (last_run.size() != rows[i].n ||
                (rows[i].n == 1 && last_run[0] != rows[i].r)))
            begin
                $display("%0t: row %0d exp %0d item(s) byte=%h st=%0d, predicted %0d",
                         $time, i, rows[i].n, rows[i].r.data, rows[i].r.status,
                         last_run.size());
                fails++;
            end
        end

        // random records, idling switched per record
        fed = 0;
        while (fed < 270)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_record($urandom_range(1, 12), $urandom_range(0, 2) == 0);
        end

        // receiver holds off while the sender keeps offering
        idle_on  = 1'b0;
        hold_req = 1'b1;
        send_record(20, 1'b0);

        // one record long enough to fill the whole history and wrap it
        idle_on = 1'b1;
        seq_q.delete();
        made = 0;
        repeat (30)
        begin
            seq_q.insert(seq_q.size(), 8'($urandom_range(9, 127)));
            made++;
        end
        while (made < HIST_SIZE + 50)
        begin
            back_dist = $urandom_range(1, made < HIST_SIZE - 1 ? made : HIST_SIZE - 1);
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 10) : 10;
            code = pair_code(back_dist, len);
            seq_q.insert(seq_q.size(), code[15:8]);
            seq_q.insert(seq_q.size(), code[7:0]);
            made += len;
        end
        code = pair_code(HIST_SIZE - 1, 10);
        seq_q.insert(seq_q.size(), code[15:8]);
        seq_q.insert(seq_q.size(), code[7:0]);
        code = pair_code(HIST_SIZE - 1, 3);
        seq_q.insert(seq_q.size(), code[15:8]);
        seq_q.insert(seq_q.size(), code[7:0]);
        seq_q.insert(seq_q.size(), 8'h41);
        flush_seq();

        // closing stretch without idling
        idle_on = 1'b0;
        repeat (8) send_record($urandom_range(1, 12), $urandom_range(0, 2) == 0);
        in_valid <= 1'b0;

        while (out_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fails == 0 && out_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
